// ----- hdl/pip_pkg.sv -----
// shared constants, codes and command type for the point-in-polygon test block
// no dependencies; used by the datapath, controller and top modules of the block
package pip_pkg;

    // default sizing
    localparam int MAX_VERTICES_DEF = 1024;
    localparam int COORD_BITS_DEF   = 24;

    // fixed field widths
    localparam int INDEX_BITS = 10;
    localparam int COUNT_BITS = 11;

    // operation codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // register stages from the store read to the parity flop
    localparam int PIPE_DEPTH = 3;

    // commands from controller to datapath
    typedef struct packed {
        logic wr_en;        // write one vertex
        logic rd_en;        // read one vertex
        logic edge_ok;      // read data closes an edge with the previous vertex
        logic query_start;  // latch point, clear parity
    } pip_cmd_t;

endpackage

// ----- hdl/pip_ram.sv -----
// generic simple dual-port ram with registered read
// no dependencies
module pip_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/pip_datapath.sv -----
// datapath: vertex stores, edge difference stage, multiplier stage, parity flop
// depends on pip_pkg and pip_ram
module pip_datapath #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pip_pkg::pip_cmd_t               cmd,
    input  logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
    input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
    input  logic [COORD_BITS-1:0]           vertex_x,
    input  logic [COORD_BITS-1:0]           vertex_y,
    input  logic [COORD_BITS-1:0]           point_x,
    input  logic [COORD_BITS-1:0]           point_y,
    output logic                            parity
);

    localparam int C = COORD_BITS;
    localparam int D = COORD_BITS + 1;
    localparam int P = 2 * D;

    logic [C-1:0] rx;
    logic [C-1:0] ry;

    logic signed [C-1:0] px_reg;
    logic signed [C-1:0] py_reg;
    logic signed [C-1:0] prevx_reg;
    logic signed [C-1:0] prevy_reg;

    logic rdv1_reg;
    logic tag1_reg;
    logic val2_reg;
    logic val3_reg;
    logic parity_reg;

    logic signed [D-1:0] a_reg;
    logic signed [D-1:0] dy_reg;
    logic signed [D-1:0] c_reg;
    logic signed [D-1:0] d_reg;
    logic signed [P-1:0] p1_reg;
    logic signed [P-1:0] p2_reg;

    logic signed [C-1:0] xi;
    logic signed [C-1:0] yi;
    logic signed [D-1:0] xi_e;
    logic signed [D-1:0] yi_e;
    logic signed [D-1:0] xj_e;
    logic signed [D-1:0] yj_e;
    logic signed [D-1:0] px_e;
    logic signed [D-1:0] py_e;
    logic                down;
    logic                span;
    logic signed [D-1:0] dy_next;
    logic signed [D-1:0] d_next;

    // coordinate stores
    pip_ram #(
        .WIDTH (C),
        .DEPTH (MAX_VERTICES)
    ) u_x_store (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (wr_addr),
        .wdata (vertex_x),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rx)
    );

    pip_ram #(
        .WIDTH (C),
        .DEPTH (MAX_VERTICES)
    ) u_y_store (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (wr_addr),
        .wdata (vertex_y),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (ry)
    );

    // edge terms from current and previous vertex
    assign xi   = $signed(rx);
    assign yi   = $signed(ry);
    assign xi_e = $signed({xi[C-1], xi});
    assign yi_e = $signed({yi[C-1], yi});
    assign xj_e = $signed({prevx_reg[C-1], prevx_reg});
    assign yj_e = $signed({prevy_reg[C-1], prevy_reg});
    assign px_e = $signed({px_reg[C-1], px_reg});
    assign py_e = $signed({py_reg[C-1], py_reg});

    // half-open y rule
    assign span = ((yi <= py_reg) && (py_reg < prevy_reg)) ||
                  ((prevy_reg <= py_reg) && (py_reg < yi));

    // dy made positive, d sign-corrected with it
    assign down    = (prevy_reg < yi);
    assign dy_next = down ? (yi_e - yj_e) : (yj_e - yi_e);
    assign d_next  = down ? (yi_e - py_e) : (py_e - yi_e);

    // valid tags through the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdv1_reg   <= 1'b0;
            tag1_reg   <= 1'b0;
            val2_reg   <= 1'b0;
            val3_reg   <= 1'b0;
            parity_reg <= 1'b0;
        end
        else
        begin
            rdv1_reg <= cmd.rd_en;
            tag1_reg <= cmd.rd_en && cmd.edge_ok;
            val2_reg <= tag1_reg && span;
            val3_reg <= val2_reg;
            if (cmd.query_start)
            begin
                parity_reg <= 1'b0;
            end
            else if (val3_reg && (p1_reg < p2_reg))
            begin
                parity_reg <= ~parity_reg;
            end
        end
    end

    // query point and previous vertex
    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            px_reg <= $signed(point_x);
            py_reg <= $signed(point_y);
        end
        if (rdv1_reg)
        begin
            prevx_reg <= xi;
            prevy_reg <= yi;
        end
    end

    // difference stage and multiplier stage
    always_ff @(posedge clk)
    begin
        a_reg  <= px_e - xi_e;
        c_reg  <= xj_e - xi_e;
        dy_reg <= dy_next;
        d_reg  <= d_next;
        p1_reg <= a_reg * dy_reg;
        p2_reg <= c_reg * d_reg;
    end

    assign parity = parity_reg;

endmodule

// ----- hdl/pip_controller.sv -----
// controller: item acceptance, vertex count register, edge walk sequencing
// depends on pip_pkg
module pip_controller #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            func,
    input  logic [pip_pkg::INDEX_BITS-1:0]  vertex_index,
    input  logic                            vertex_count_we,
    input  logic [pip_pkg::COUNT_BITS-1:0]  vertex_count,
    output logic                            busy,
    output logic                            done,
    output pip_pkg::pip_cmd_t               cmd,
    output logic [$clog2(MAX_VERTICES)-1:0] wr_addr,
    output logic [$clog2(MAX_VERTICES)-1:0] rd_addr
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = AW + 1;
    localparam int DW = $clog2(pip_pkg::PIPE_DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [DW-1:0] DRAIN_LAST = DW'(pip_pkg::PIPE_DEPTH - 1);

    logic [1:0]                     state_reg;
    logic [1:0]                     state_next;
    logic [AW-1:0]                  addr_reg;
    logic [AW-1:0]                  addr_next;
    logic [AW-1:0]                  last_reg;
    logic [AW-1:0]                  last_next;
    logic                           first_reg;
    logic                           first_next;
    logic [DW-1:0]                  cnt_reg;
    logic [DW-1:0]                  cnt_next;
    logic [pip_pkg::COUNT_BITS-1:0] count_reg;
    logic [NW-1:0]                  n_sat;
    logic                           index_ok;

    // count saturated at the store depth
    assign n_sat = (32'(count_reg) > 32'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(count_reg);

    assign index_ok = (32'(vertex_index) < 32'(MAX_VERTICES));
    assign wr_addr  = AW'(32'(vertex_index));
    assign rd_addr  = addr_reg;
    assign busy     = (state_reg != ST_IDLE);
    assign done     = (state_reg == ST_DONE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        last_next  = last_reg;
        first_next = first_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (func == pip_pkg::FUNC_QUERY)
                    begin
                        cmd.query_start = 1'b1;
                        if (n_sat == '0)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_READ;
                            addr_next  = AW'(n_sat - NW'(1));
                            last_next  = AW'(n_sat - NW'(1));
                            first_next = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.wr_en = index_ok;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd_en   = 1'b1;
                cmd.edge_ok = ~first_reg;
                if (first_reg)
                begin
                    first_next = 1'b0;
                    addr_next  = '0;
                end
                else if (addr_reg == last_reg)
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (cnt_reg == DRAIN_LAST)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + DW'(1);
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            addr_reg  <= '0;
            last_reg  <= '0;
            first_reg <= 1'b0;
            cnt_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            last_reg  <= last_next;
            first_reg <= first_next;
            cnt_reg   <= cnt_next;
            if (vertex_count_we)
            begin
                count_reg <= vertex_count;
            end
        end
    end

endmodule

// ----- hdl/point_in_polygon_test_core.sv -----
// point-in-polygon crossing-parity test: load item writes one vertex (if vertex_index is in range) and gives no result
// query item: strobe after the edge walk and drain (n = saturated vertex_count; with n zero, no walk or drain);
// edge walk reads one vertex per cycle from the stores, n+1 reads, then 3 pipeline stages;
// next item is taken the cycle after the strobe
// async active-low reset clears control and vertex_count; vertex stores are not cleared
// results cannot be stalled: inside_res is valid only in the done cycle
module point_in_polygon_test_core #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           func,
    input  logic [pip_pkg::INDEX_BITS-1:0] vertex_index,
    input  logic [COORD_BITS-1:0]          vertex_x,
    input  logic [COORD_BITS-1:0]          vertex_y,
    input  logic [COORD_BITS-1:0]          point_x,
    input  logic [COORD_BITS-1:0]          point_y,
    output logic                           done,
    output logic                           inside_res,
    input  logic                           vertex_count_we,
    input  logic [pip_pkg::COUNT_BITS-1:0] vertex_count
);

    pip_pkg::pip_cmd_t               cmd;
    logic [$clog2(MAX_VERTICES)-1:0] wr_addr;
    logic [$clog2(MAX_VERTICES)-1:0] rd_addr;

    // sequencing
    pip_controller #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .func            (func),
        .vertex_index    (vertex_index),
        .vertex_count_we (vertex_count_we),
        .vertex_count    (vertex_count),
        .busy            (busy),
        .done            (done),
        .cmd             (cmd),
        .wr_addr         (wr_addr),
        .rd_addr         (rd_addr)
    );

    // stores and edge arithmetic
    pip_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr),
        .vertex_x (vertex_x),
        .vertex_y (vertex_y),
        .point_x  (point_x),
        .point_y  (point_y),
        .parity   (inside_res)
    );

    // an accepted query always occupies the block
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == pip_pkg::FUNC_QUERY)) |=> busy)
        else $error("query item accepted but block not busy");

    // a load item never occupies the block
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (func == pip_pkg::FUNC_LOAD)) |=> !busy)
        else $error("load item left block busy");

    // strobe lasts one cycle and releases the block
    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!busy && !done))
        else $error("result strobe not followed by idle");

    // no store read while idle
    a_no_idle_read: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !cmd.rd_en)
        else $error("store read issued while idle");

endmodule
